>>> sv/smfh_pkg.sv
`default_nettype none

package smfh_pkg;

   typedef logic [63:0] hash_type;

   // item kind codes
   localparam logic [1:0] KindHeader = 2'd0;
   localparam logic [1:0] KindVertex = 2'd1;
   localparam logic [1:0] KindIndex  = 2'd2;

   localparam hash_type FnvBasis = 64'hcbf29ce484222325;

   // prime 0x100000001b3 = 2^40 + 0x1b3
   localparam logic [8:0] FnvPrimeLow   = 9'h1b3;
   localparam int         FnvPrimeShift = 40;

   // vertex_count / 100 as (vertex_count * StepRecip) >> StepShift, exact for 31 bits
   localparam logic [31:0] StepRecip = 32'd2748779070;
   localparam int          StepShift = 38;

   localparam int StepWidth  = 25;
   localparam int CountWidth = 31;

endpackage

`default_nettype wire

>>> sv/smfh_if.sv
`default_nettype none

interface smfh_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [30:0] vertex_count;
   logic [30:0] index_count;
   logic [31:0] x_word;
   logic [31:0] y_word;
   logic [31:0] z_word;
   logic signed [31:0] tri_index;
   logic        last;

   modport source (output valid, kind, vertex_count, index_count, x_word, y_word,
                   z_word, tri_index, last, input ready);
   modport sink   (input valid, kind, vertex_count, index_count, x_word, y_word,
                   z_word, tri_index, last, output ready);
endinterface

interface smfh_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] hash;

   modport source (output valid, hash, input ready);
   modport sink   (input valid, hash, output ready);
endinterface

`default_nettype wire

>>> sv/smfh_fold_unit.sv
`default_nettype none

// one FNV-1a fold: (acc ^ word) * prime, modulo 2^64
module smfh_fold_unit (
   input  smfh_pkg::hash_type acc,
   input  smfh_pkg::hash_type word,
   output smfh_pkg::hash_type result
);

   smfh_pkg::hash_type mixed;
   smfh_pkg::hash_type low_prod;

   assign mixed    = acc ^ word;
   assign low_prod = mixed * 64'(smfh_pkg::FnvPrimeLow);
   // add the 2^40 term of the prime as a shift
   assign result   = low_prod + (mixed << smfh_pkg::FnvPrimeShift);

endmodule

`default_nettype wire

>>> sv/sampled_mesh_fnv_hash.sv
// A word marked last adds tail folds of the three held indices when more than
// three indices are expected, then loads the result register in S_EMIT, held
// while the previous result is unread. Words are taken one at a time, only in
// S_IDLE. The one shared fold unit does one fold per cycle in S_ITEM or S_TAIL.
// Reset (synchronous, active high) restores the offset basis and a step of one,
// clears counters and held indices, drops any result.
`default_nettype none

module sampled_mesh_fnv_hash (
   input  logic       clock,
   input  logic       reset,
   smfh_req_if.sink   req_chan,
   smfh_rsp_if.source rsp_chan
);

   // S_ITEM runs the folds of the word itself, S_TAIL the folds of the held
   // indices at emission, S_EMIT waits for the result register to be free.
   typedef enum logic [1:0] {S_IDLE, S_ITEM, S_TAIL, S_EMIT} state_type;

   localparam int SW = smfh_pkg::StepWidth;
   localparam int CW = smfh_pkg::CountWidth;

   state_type          state_ff,  state_in;
   smfh_pkg::hash_type hash_acc_ff, hash_acc_in;   // committed mesh hash
   smfh_pkg::hash_type fold_acc_ff, fold_acc_in;   // working value of the fold unit
   smfh_pkg::hash_type queue_ff [3];               // words waiting to be folded
   smfh_pkg::hash_type queue_in [3];
   logic [1:0]         fold_cnt_ff, fold_cnt_in;
   logic               last_ff, last_in;
   logic               header_ff, header_in;
   logic [CW-1:0]      vcount_ff, vcount_in;
   logic [62:0]        prod_ff, prod_in;
   logic [SW-1:0]      step_ff, step_in;
   logic [SW-1:0]      countdown_ff, countdown_in;
   logic [CW-1:0]      expected_ff, expected_in;
   logic [CW-1:0]      seen_ff, seen_in;
   logic [31:0]        tail_ff [3];
   logic [31:0]        tail_in [3];
   logic               rsp_valid_ff, rsp_valid_in;
   smfh_pkg::hash_type rsp_hash_ff, rsp_hash_in;

   smfh_pkg::hash_type fold_res;
   logic               accept;
   logic [SW-1:0]      step_quot;

   smfh_fold_unit u_fold (
      .acc    (fold_acc_ff),
      .word   (queue_ff[0]),
      .result (fold_res)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept         = req_chan.valid && (state_ff == S_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.hash  = rsp_hash_ff;

   // quotient bits of vertex_count / 100
   assign step_quot = prod_ff[smfh_pkg::StepShift +: SW];

   always_comb begin
      state_in     = state_ff;
      hash_acc_in  = hash_acc_ff;
      fold_acc_in  = fold_acc_ff;
      queue_in     = queue_ff;
      fold_cnt_in  = fold_cnt_ff;
      last_in      = last_ff;
      header_in    = header_ff;
      vcount_in    = vcount_ff;
      prod_in      = prod_ff;
      step_in      = step_ff;
      countdown_in = countdown_ff;
      expected_in  = expected_ff;
      seen_in      = seen_ff;
      tail_in      = tail_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_hash_in  = rsp_hash_ff;

      // drop the result once taken
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in    = S_ITEM;
               last_in     = req_chan.last;
               header_in   = (req_chan.kind == smfh_pkg::KindHeader);
               fold_cnt_in = 2'd0;
               fold_acc_in = hash_acc_ff;
               case (req_chan.kind)
                  smfh_pkg::KindHeader: begin
                     // restart from the basis, fold both counts
                     vcount_in    = req_chan.vertex_count;
                     fold_acc_in  = smfh_pkg::FnvBasis;
                     queue_in[0]  = {33'd0, req_chan.vertex_count};
                     queue_in[1]  = {33'd0, req_chan.index_count};
                     fold_cnt_in  = 2'd2;
                     countdown_in = '0;
                     expected_in  = req_chan.index_count;
                     seen_in      = '0;
                     tail_in[0]   = '0;
                     tail_in[1]   = '0;
                     tail_in[2]   = '0;
                  end
                  smfh_pkg::KindVertex: begin
                     if (countdown_ff == '0) begin
                        queue_in[0]  = {32'd0, req_chan.x_word};
                        queue_in[1]  = {32'd0, req_chan.y_word};
                        queue_in[2]  = {32'd0, req_chan.z_word};
                        fold_cnt_in  = 2'd3;
                        countdown_in = step_ff - SW'(1);
                     end else begin
                        countdown_in = countdown_ff - SW'(1);
                     end
                  end
                  smfh_pkg::KindIndex: begin
                     if (expected_ff >= CW'(3) && seen_ff < CW'(3)) begin
                        queue_in[0] = 64'(req_chan.tri_index);
                        fold_cnt_in = 2'd1;
                     end
                     tail_in[0] = tail_ff[1];
                     tail_in[1] = tail_ff[2];
                     tail_in[2] = req_chan.tri_index;
                     if (seen_ff != '1) begin
                        seen_in = seen_ff + CW'(1);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_ITEM: begin
            if (fold_cnt_ff != 2'd0) begin
               fold_acc_in = fold_res;
               hash_acc_in = fold_res;
               queue_in[0] = queue_ff[1];
               queue_in[1] = queue_ff[2];
               fold_cnt_in = fold_cnt_ff - 2'd1;
            end
            // header: multiply on the first fold, take the step on the second
            if (header_ff && fold_cnt_ff == 2'd2) begin
               prod_in = 63'(vcount_ff) * 63'(smfh_pkg::StepRecip);
            end
            if (header_ff && fold_cnt_ff == 2'd1) begin
               step_in = (step_quot == '0) ? SW'(1) : step_quot;
            end
            if (fold_cnt_ff <= 2'd1) begin
               if (!last_ff) begin
                  state_in = S_IDLE;
               end else if (expected_ff > CW'(3)) begin
                  // fold held indices, oldest first, into the working value only
                  queue_in[0] = 64'(signed'(tail_ff[0]));
                  queue_in[1] = 64'(signed'(tail_ff[1]));
                  queue_in[2] = 64'(signed'(tail_ff[2]));
                  fold_cnt_in = 2'd3;
                  state_in    = S_TAIL;
               end else begin
                  state_in = S_EMIT;
               end
            end
         end

         S_TAIL: begin
            fold_acc_in = fold_res;
            queue_in[0] = queue_ff[1];
            queue_in[1] = queue_ff[2];
            fold_cnt_in = fold_cnt_ff - 2'd1;
            if (fold_cnt_ff <= 2'd1) begin
               state_in = S_EMIT;
            end
         end

         S_EMIT: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_hash_in  = fold_acc_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         hash_acc_ff  <= smfh_pkg::FnvBasis;
         fold_cnt_ff  <= 2'd0;
         last_ff      <= 1'b0;
         header_ff    <= 1'b0;
         step_ff      <= SW'(1);
         countdown_ff <= '0;
         expected_ff  <= '0;
         seen_ff      <= '0;
         tail_ff[0]   <= '0;
         tail_ff[1]   <= '0;
         tail_ff[2]   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hash_acc_ff  <= hash_acc_in;
         fold_cnt_ff  <= fold_cnt_in;
         last_ff      <= last_in;
         header_ff    <= header_in;
         step_ff      <= step_in;
         countdown_ff <= countdown_in;
         expected_ff  <= expected_in;
         seen_ff      <= seen_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      // payload, no reset
      fold_acc_ff <= fold_acc_in;
      queue_ff    <= queue_in;
      vcount_ff   <= vcount_in;
      prod_ff     <= prod_in;
      rsp_hash_ff <= rsp_hash_in;
   end

endmodule

`default_nettype wire

>>> sv/smfh_checker.sv
`default_nettype none

module smfh_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [63:0] rsp_hash
);

   // a stalled result word stays
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_hash))
      else $error("result hash changed while stalled");

   // one word at a time: busy right after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted back to back");

   // a result never appears in the cycle after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("result appeared too early");

endmodule

bind sampled_mesh_fnv_hash smfh_checker u_smfh_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_hash  (rsp_chan.hash)
);

`default_nettype wire
